### design/hsq_pkg.sv
package hsq_pkg;

    // panel geometry
    localparam int SCAN_ROWS   = 32;
    localparam int PANEL_COLS  = 128;

    localparam int STORE_WORDS = SCAN_ROWS * PANEL_COLS;
    localparam int STORE_AW    = $clog2(STORE_WORDS);
    localparam int ROW_W       = $clog2(SCAN_ROWS);
    localparam int COL_STEPS   = 4 * PANEL_COLS;
    localparam int ROW_STEPS   = COL_STEPS + 6;
    localparam int STEP_W      = $clog2(ROW_STEPS);

    // fixed field widths
    localparam int WORD_W      = 12;
    localparam int ADDR_W      = 5;

    // item commands
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // column phases
    localparam logic [1:0] PH_CLR_DATA = 2'd0;
    localparam logic [1:0] PH_SET_DATA = 2'd1;
    localparam logic [1:0] PH_CLK_HI   = 2'd2;
    localparam logic [1:0] PH_CLK_LO   = 2'd3;

    // end-of-row phases
    localparam logic [2:0] TL_BLANK    = 3'd0;
    localparam logic [2:0] TL_CLR_ADDR = 3'd1;
    localparam logic [2:0] TL_SET_ADDR = 3'd2;
    localparam logic [2:0] TL_LATCH_HI = 3'd3;
    localparam logic [2:0] TL_LATCH_LO = 3'd4;
    localparam logic [2:0] TL_UNBLANK  = 3'd5;

    // pin update operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_HOLD     = 4'd0;
    localparam logic [OP_W-1:0] OP_CLR_DATA = 4'd1;
    localparam logic [OP_W-1:0] OP_SET_DATA = 4'd2;
    localparam logic [OP_W-1:0] OP_CLK_HI   = 4'd3;
    localparam logic [OP_W-1:0] OP_CLK_LO   = 4'd4;
    localparam logic [OP_W-1:0] OP_BLANK    = 4'd5;
    localparam logic [OP_W-1:0] OP_CLR_ADDR = 4'd6;
    localparam logic [OP_W-1:0] OP_SET_ADDR = 4'd7;
    localparam logic [OP_W-1:0] OP_LATCH_HI = 4'd8;
    localparam logic [OP_W-1:0] OP_LATCH_LO = 4'd9;
    localparam logic [OP_W-1:0] OP_UNBLANK  = 4'd10;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [ROW_W-1:0] row;
    } pin_op_t;

endpackage

### design/hsq_frame_store.sv
module hsq_frame_store
    import hsq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [STORE_AW-1:0] wr_addr,
    input  logic [WORD_W-1:0]   wr_data,
    input  logic                rd_en,
    input  logic [STORE_AW-1:0] rd_addr,
    output logic [WORD_W-1:0]   rd_data,
    output logic                busy
);

    logic [WORD_W-1:0]   mem [STORE_WORDS];
    logic [WORD_W-1:0]   rd_data_reg;
    logic                busy_reg;
    logic [STORE_AW-1:0] clr_reg;

    logic                mem_we;
    logic [STORE_AW-1:0] mem_wa;
    logic [WORD_W-1:0]   mem_wd;

    // clearing pass owns the write port after reset
    assign mem_we = busy_reg | wr_en;
    assign mem_wa = busy_reg ? clr_reg : wr_addr;
    assign mem_wd = busy_reg ? '0 : wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            clr_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (clr_reg == STORE_AW'(STORE_WORDS - 1))
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

### design/hsq_step_seq.sv
module hsq_step_seq
    import hsq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tick,
    output pin_op_t             step_op,
    output logic [STORE_AW-1:0] rd_addr
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [ROW_W-1:0]  scan_row_reg;
    logic [ROW_W-1:0]  scan_row_next;
    logic [2:0]        tail;

    assign tail = 3'(step_reg - STEP_W'(COL_STEPS));

    // data word for this step's column
    assign rd_addr = STORE_AW'(int'(scan_row_reg) * PANEL_COLS + int'(step_reg[STEP_W-1:2]));

    always_comb
    begin
        step_op.row = scan_row_reg;
        step_op.op  = OP_HOLD;
        if (int'(step_reg) < COL_STEPS)
        begin
            unique case (step_reg[1:0])
                PH_CLR_DATA: step_op.op = OP_CLR_DATA;
                PH_SET_DATA: step_op.op = OP_SET_DATA;
                PH_CLK_HI:   step_op.op = OP_CLK_HI;
                PH_CLK_LO:   step_op.op = OP_CLK_LO;
                default:     step_op.op = OP_HOLD;
            endcase
        end
        else
        begin
            unique case (tail)
                TL_BLANK:    step_op.op = OP_BLANK;
                TL_CLR_ADDR: step_op.op = OP_CLR_ADDR;
                TL_SET_ADDR: step_op.op = OP_SET_ADDR;
                TL_LATCH_HI: step_op.op = OP_LATCH_HI;
                TL_LATCH_LO: step_op.op = OP_LATCH_LO;
                TL_UNBLANK:  step_op.op = OP_UNBLANK;
                default:     step_op.op = OP_HOLD;
            endcase
        end
    end

    always_comb
    begin
        step_next     = step_reg + 1'b1;
        scan_row_next = scan_row_reg;
        if (step_reg == STEP_W'(ROW_STEPS - 1))
        begin
            step_next = '0;
            if (scan_row_reg == ROW_W'(SCAN_ROWS - 1))
            begin
                scan_row_next = '0;
            end
            else
            begin
                scan_row_next = scan_row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= '0;
            scan_row_reg <= '0;
        end
        else if (tick)
        begin
            step_reg     <= step_next;
            scan_row_reg <= scan_row_next;
        end
    end

endmodule

### design/hsq_pin_drive.sv
module hsq_pin_drive
    import hsq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  pin_op_t           op_in,
    input  logic [WORD_W-1:0] rd_data,
    input  logic              pin_stall,
    output logic              busy,
    output logic              pin_valid,
    output logic [WORD_W-1:0] color_bits,
    output logic              shift_clock,
    output logic              latch,
    output logic              blank,
    output logic [ADDR_W-1:0] row_select
);

    logic              s1_valid_reg;
    pin_op_t           s1_op_reg;
    logic              s1_adv;
    logic              out_valid_reg;

    logic [WORD_W-1:0] data_reg, data_next;
    logic              clk_line_reg, clk_line_next;
    logic              latch_reg, latch_next;
    logic              blank_reg, blank_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;

    assign s1_adv = s1_valid_reg && (!out_valid_reg || !pin_stall);
    assign busy   = s1_valid_reg && !s1_adv;

    always_comb
    begin
        data_next     = data_reg;
        clk_line_next = clk_line_reg;
        latch_next    = latch_reg;
        blank_next    = blank_reg;
        addr_next     = addr_reg;
        unique case (s1_op_reg.op)
            OP_CLR_DATA:
            begin
                data_next     = '0;
                clk_line_next = 1'b0;
            end
            OP_SET_DATA: data_next  = data_reg | rd_data;
            OP_CLK_HI:   clk_line_next = 1'b1;
            OP_CLK_LO:   clk_line_next = 1'b0;
            OP_BLANK:    blank_next = 1'b1;
            OP_CLR_ADDR: addr_next  = '0;
            OP_SET_ADDR: addr_next  = addr_reg | ADDR_W'(s1_op_reg.row);
            OP_LATCH_HI: latch_next = 1'b1;
            OP_LATCH_LO: latch_next = 1'b0;
            OP_UNBLANK:  blank_next = 1'b0;
            default:     data_next  = data_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_op_reg     <= '0;
            out_valid_reg <= 1'b0;
            data_reg      <= '0;
            clk_line_reg  <= 1'b0;
            latch_reg     <= 1'b0;
            blank_reg     <= 1'b1;
            addr_reg      <= '0;
        end
        else
        begin
            if (load)
            begin
                s1_valid_reg <= 1'b1;
                s1_op_reg    <= op_in;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                data_reg      <= data_next;
                clk_line_reg  <= clk_line_next;
                latch_reg     <= latch_next;
                blank_reg     <= blank_next;
                addr_reg      <= addr_next;
            end
            else if (!pin_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign pin_valid   = out_valid_reg;
    assign color_bits  = data_reg;
    assign shift_clock = clk_line_reg;
    assign latch       = latch_reg;
    assign blank       = blank_reg;
    assign row_select  = addr_reg;

endmodule

### design/hub75_panel_scan_sequencer.sv
// Pin-level scan sequencer for two chained hub75 panels with 1-bit color. Each
// word on the command channel is either a pixel write into the frame store or one
// scan tick, and each word returns one word on the pin channel holding the pin
// levels after it. One word is taken per clock while cmd_stall is low; a result
// is held first in the frame store's registered read port, then in the pin update
// register. After reset the block first walks the frame store once to clear it
// (4096 words at 32 rows by 128 columns), holding cmd_stall high meanwhile. A row
// takes 518 ticks: four per column (clear data and clock, set data, clock high,
// clock low), then blank, clear address, set address, latch high, latch low,
// unblank; the row count wraps after the last row.
// A write with a row or column outside the panel is dropped but still answered.
module hub75_panel_scan_sequencer
    import hsq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    // command channel
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  logic              command,
    input  logic [4:0]        row,
    input  logic [6:0]        col,
    input  logic [WORD_W-1:0] pixel_bits,

    // pin level channel
    output logic              pin_valid,
    input  logic              pin_stall,
    output logic [WORD_W-1:0] color_bits,
    output logic              shift_clock,
    output logic              latch,
    output logic              blank,
    output logic [ADDR_W-1:0] row_select
);

    logic                cmd_accept;
    logic                tick;
    logic                store_busy;
    logic                pipe_busy;
    logic                wr_en;
    logic [STORE_AW-1:0] wr_addr;
    logic [STORE_AW-1:0] rd_addr;
    logic [WORD_W-1:0]   rd_data;
    pin_op_t             step_op;
    pin_op_t             cur_op;

    // stall while clearing or while the update stage is blocked downstream
    assign cmd_stall  = store_busy | pipe_busy;
    assign cmd_accept = cmd_valid & !cmd_stall;
    assign tick       = cmd_accept && (command == CMD_TICK);

    // writes land at the accept edge, so a later tick's read sees them
    assign wr_en   = cmd_accept && (command == CMD_WRITE)
                     && (int'(row) < SCAN_ROWS) && (int'(col) < PANEL_COLS);
    assign wr_addr = STORE_AW'(int'(row) * PANEL_COLS + int'(col));

    // a write word leaves the pins as they are
    always_comb
    begin
        cur_op = step_op;
        if (command == CMD_WRITE)
        begin
            cur_op.op = OP_HOLD;
        end
    end

    hsq_frame_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (pixel_bits),
        .rd_en   (tick),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .busy    (store_busy)
    );

    hsq_step_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick),
        .step_op (step_op),
        .rd_addr (rd_addr)
    );

    hsq_pin_drive u_pins (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (cmd_accept),
        .op_in       (cur_op),
        .rd_data     (rd_data),
        .pin_stall   (pin_stall),
        .busy        (pipe_busy),
        .pin_valid   (pin_valid),
        .color_bits  (color_bits),
        .shift_clock (shift_clock),
        .latch       (latch),
        .blank       (blank),
        .row_select  (row_select)
    );

    // the latch pulse always sits inside the blanked window
    a_latch_blanked: assert property (@(posedge clk) disable iff (!rst_n)
        latch |-> blank)
        else $error("latch high while display not blanked");

    // shift clock and latch are never high together
    a_clk_latch_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(shift_clock && latch))
        else $error("shift clock and latch both high");

    // no command word is taken during the clearing pass
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        store_busy |-> !cmd_accept)
        else $error("command word accepted while frame store clearing");

    // a pin word follows an accepted command word while pin_stall stays low
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_accept && !pin_stall) ##1 !pin_stall |=> pin_valid)
        else $error("missing pin word after command word");

endmodule
